FILE: hdl/srs_pkg.sv
// ----------------------------------------------------------------------------
// Sensor recovery supervisor package
// Shared widths, event and register codes, recovery mode encoding and the
// structures that pass configuration and results between the modules.
// ----------------------------------------------------------------------------
package srs_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned MS_W    = 16;
    localparam int unsigned ATT_W   = 4;
    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned STATE_W = 2;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned IDX_W   = ADDR_W - 2;

    // Event codes carried by an input item; the fourth code means nothing.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_GOOD         = 2'd0,
        FUNC_SENSOR_RESET = 2'd1,
        FUNC_HEALTH       = 2'd2
    } func_t;

    // Register indexes on the configuration port.
    typedef enum logic [IDX_W-1:0] {
        REG_FRESH_TIMEOUT = 3'd0,
        REG_RECOVERY_TRIG = 3'd1,
        REG_REENABLE_WAIT = 3'd2,
        REG_SOFT_ATT_MAX  = 3'd3,
        REG_RESET_PULSE   = 3'd4,
        REG_BOOT_WAIT     = 3'd5
    } reg_idx_t;

    // Recovery mode, one-hot.
    typedef enum logic [3:0] {
        MODE_HEALTHY = 4'b0001,
        MODE_SOFT    = 4'b0010,
        MODE_PULSE   = 4'b0100,
        MODE_BOOT    = 4'b1000
    } mode_t;

    // Encoded mode as reported on recovery_state.
    localparam logic [STATE_W-1:0] STATE_HEALTHY = 2'd0;
    localparam logic [STATE_W-1:0] STATE_SOFT    = 2'd1;
    localparam logic [STATE_W-1:0] STATE_PULSE   = 2'd2;
    localparam logic [STATE_W-1:0] STATE_BOOT    = 2'd3;

    typedef struct packed {
        logic [MS_W-1:0]  fresh_timeout_ms;
        logic [MS_W-1:0]  recovery_trigger_ms;
        logic [MS_W-1:0]  reenable_wait_ms;
        logic [ATT_W-1:0] soft_attempts_max;
        logic [MS_W-1:0]  reset_pulse_ms;
        logic [MS_W-1:0]  boot_wait_ms;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        fresh_timeout_ms:    16'd100,
        recovery_trigger_ms: 16'd1000,
        reenable_wait_ms:    16'd600,
        soft_attempts_max:   4'd3,
        reset_pulse_ms:      16'd10,
        boot_wait_ms:        16'd300
    };

    typedef struct packed {
        logic               request_reenable;
        logic               reset_line_low;
        logic [STATE_W-1:0] recovery_state;
        logic [ATT_W-1:0]   attempts_used;
        logic               data_fresh;
        logic               attitude_invalid;
    } res_t;

    // Map the one-hot mode onto its reported code.
    function automatic logic [STATE_W-1:0] mode_code(mode_t m);
        logic [STATE_W-1:0] code;
        case (m)
            MODE_SOFT:  code = STATE_SOFT;
            MODE_PULSE: code = STATE_PULSE;
            MODE_BOOT:  code = STATE_BOOT;
            default:    code = STATE_HEALTHY;
        endcase
        return code;
    endfunction

endpackage

FILE: hdl/srs_regs.sv
// ----------------------------------------------------------------------------
// Sensor recovery supervisor configuration registers
// APB-style register file holding the timeouts and the attempt limit.
// ----------------------------------------------------------------------------
module srs_regs
    import srs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic             wr_en;
    logic [IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[ADDR_W-1:2];
    assign cfg    = cfg_reg;

    // Write decode; addresses beyond the last register are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_FRESH_TIMEOUT: cfg_next.fresh_timeout_ms    = pwdata[MS_W-1:0];
                REG_RECOVERY_TRIG: cfg_next.recovery_trigger_ms = pwdata[MS_W-1:0];
                REG_REENABLE_WAIT: cfg_next.reenable_wait_ms    = pwdata[MS_W-1:0];
                REG_SOFT_ATT_MAX:  cfg_next.soft_attempts_max   = pwdata[ATT_W-1:0];
                REG_RESET_PULSE:   cfg_next.reset_pulse_ms      = pwdata[MS_W-1:0];
                REG_BOOT_WAIT:     cfg_next.boot_wait_ms        = pwdata[MS_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read decode, zero extended.
    always_comb
    begin
        unique case (idx)
            REG_FRESH_TIMEOUT: prdata = DATA_W'(cfg_reg.fresh_timeout_ms);
            REG_RECOVERY_TRIG: prdata = DATA_W'(cfg_reg.recovery_trigger_ms);
            REG_REENABLE_WAIT: prdata = DATA_W'(cfg_reg.reenable_wait_ms);
            REG_SOFT_ATT_MAX:  prdata = DATA_W'(cfg_reg.soft_attempts_max);
            REG_RESET_PULSE:   prdata = DATA_W'(cfg_reg.reset_pulse_ms);
            REG_BOOT_WAIT:     prdata = DATA_W'(cfg_reg.boot_wait_ms);
            default:           prdata = '0;
        endcase
    end

endmodule

FILE: hdl/srs_core.sv
// ----------------------------------------------------------------------------
// Sensor recovery supervisor core
// Holds the recovery state and applies one event per cycle in which step is
// high, producing the result fields that show the state after the event.
// ----------------------------------------------------------------------------
module srs_core
    import srs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [FUNC_W-1:0] func,
    input  logic [TIME_W-1:0] now_ms,
    input  cfg_t              cfg,
    output res_t              result
);

    localparam logic [ATT_W-1:0] ATT_ONE = ATT_W'(1);

    mode_t             mode_reg;
    mode_t             mode_next;
    logic [TIME_W-1:0] since_reg;
    logic [TIME_W-1:0] since_next;
    logic [ATT_W-1:0]  attempts_reg;
    logic [ATT_W-1:0]  attempts_next;
    logic [TIME_W-1:0] last_good_reg;
    logic [TIME_W-1:0] last_good_next;
    logic              seen_reg;
    logic              seen_next;
    logic              drive_low_reg;
    logic              drive_low_next;

    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] age_after;
    logic [TIME_W-1:0] elapsed;
    logic              fresh_before;
    logic              req;
    logic              invalid;

    // Elapsed times wrap modulo 2^32.
    assign age          = now_ms - last_good_reg;
    assign elapsed      = now_ms - since_reg;
    assign fresh_before = seen_reg && (age < TIME_W'(cfg.fresh_timeout_ms));

    // Event handling and the recovery sequence.
    always_comb
    begin
        mode_next      = mode_reg;
        since_next     = since_reg;
        attempts_next  = attempts_reg;
        last_good_next = last_good_reg;
        seen_next      = seen_reg;
        drive_low_next = drive_low_reg;
        req            = 1'b0;
        invalid        = 1'b0;

        case (func)
            FUNC_GOOD:
            begin
                last_good_next = now_ms;
                seen_next      = 1'b1;
            end
            FUNC_SENSOR_RESET:
            begin
                invalid       = 1'b1;
                req           = 1'b1;
                mode_next     = MODE_SOFT;
                since_next    = now_ms;
                attempts_next = ATT_ONE;
            end
            FUNC_HEALTH:
            begin
                if (fresh_before)
                begin
                    if (mode_reg != MODE_HEALTHY)
                    begin
                        mode_next     = MODE_HEALTHY;
                        attempts_next = '0;
                    end
                end
                else
                begin
                    unique case (mode_reg)
                        MODE_HEALTHY:
                        begin
                            if (seen_reg && (age >= TIME_W'(cfg.recovery_trigger_ms)))
                            begin
                                req           = 1'b1;
                                mode_next     = MODE_SOFT;
                                since_next    = now_ms;
                                attempts_next = ATT_ONE;
                            end
                        end
                        MODE_SOFT:
                        begin
                            if (elapsed >= TIME_W'(cfg.reenable_wait_ms))
                            begin
                                if (attempts_reg < cfg.soft_attempts_max)
                                begin
                                    req           = 1'b1;
                                    attempts_next = attempts_reg + ATT_ONE;
                                end
                                else
                                begin
                                    drive_low_next = 1'b1;
                                    mode_next      = MODE_PULSE;
                                end
                                since_next = now_ms;
                            end
                        end
                        MODE_PULSE:
                        begin
                            if (elapsed >= TIME_W'(cfg.reset_pulse_ms))
                            begin
                                drive_low_next = 1'b0;
                                mode_next      = MODE_BOOT;
                                since_next     = now_ms;
                            end
                        end
                        MODE_BOOT:
                        begin
                            if (elapsed >= TIME_W'(cfg.boot_wait_ms))
                            begin
                                req           = 1'b1;
                                attempts_next = '0;
                                mode_next     = MODE_SOFT;
                                since_next    = now_ms;
                            end
                        end
                        default:
                        begin
                            mode_next = mode_reg;
                        end
                    endcase
                end
            end
            default:
            begin
                req = 1'b0;
            end
        endcase
    end

    // Freshness as seen after the event has been applied.
    assign age_after = now_ms - last_good_next;

    always_comb
    begin
        result.request_reenable = req;
        result.reset_line_low   = drive_low_next;
        result.recovery_state   = mode_code(mode_next);
        result.attempts_used    = attempts_next;
        result.data_fresh       = seen_next && (age_after < TIME_W'(cfg.fresh_timeout_ms));
        result.attitude_invalid = invalid;
    end

    // State registers, updated once per processed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_HEALTHY;
            since_reg     <= '0;
            attempts_reg  <= '0;
            last_good_reg <= '0;
            seen_reg      <= 1'b0;
            drive_low_reg <= 1'b0;
        end
        else if (step)
        begin
            mode_reg      <= mode_next;
            since_reg     <= since_next;
            attempts_reg  <= attempts_next;
            last_good_reg <= last_good_next;
            seen_reg      <= seen_next;
            drive_low_reg <= drive_low_next;
        end
    end

endmodule

FILE: hdl/sensor_recovery_supervisor_top.sv
// ----------------------------------------------------------------------------
// Sensor recovery supervisor
// Watches timestamped sensor events and drives re-enable requests and a
// hardware reset pulse when good attitude reports stop arriving.
//
// Usage:
// The input channel (in_valid, in_stall, func, now_ms) carries one event
// item per cycle unless stalled; the output channel (out_valid, out_stall and
// the result fields) returns exactly one result item for each event, in order.
// An item taken sits in the input register until the output register is
// free; it is then applied to the recovery state at the edge where its
// result is written to the output register, which offers it to the receiver.
// Throughput is one item per cycle while the receiver does not stall: the
// state update is a few subtractions and compares done combinationally
// between the input register and the output register.
// When the receiver stalls, the output register holds its result, the input
// register holds the next item, and in_stall rises only while both are full.
// Reset clears the recovery state (healthy, no report seen, reset line
// released) and loads the default timeouts; there is no clearing sequence.
// Timeouts are set through the APB port, one register per word, while idle.
// ----------------------------------------------------------------------------
module sensor_recovery_supervisor_top
    import srs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [FUNC_W-1:0]   func,
    input  logic [TIME_W-1:0]   now_ms,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                request_reenable,
    output logic                reset_line_low,
    output logic [STATE_W-1:0]  recovery_state,
    output logic [ATT_W-1:0]    attempts_used,
    output logic                data_fresh,
    output logic                attitude_invalid
);

    cfg_t              cfg;
    logic              in_vld_reg;
    logic              in_vld_next;
    logic [FUNC_W-1:0] func_reg;
    logic [TIME_W-1:0] now_reg;
    logic              out_vld_reg;
    logic              out_vld_next;
    res_t              res_reg;
    res_t              res_comb;
    logic              out_free;
    logic              move;
    logic              accept;

    srs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Flow control between the input register and the output register.
    assign out_free = !out_vld_reg || !out_stall;
    assign move     = in_vld_reg && out_free;
    assign in_stall = in_vld_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (move)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (move)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_vld_reg && !out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Input item register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            now_reg  <= now_ms;
        end
    end

    srs_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (move),
        .func   (func_reg),
        .now_ms (now_reg),
        .cfg    (cfg),
        .result (res_comb)
    );

    // Result register.
    always_ff @(posedge clk)
    begin
        if (move)
        begin
            res_reg <= res_comb;
        end
    end

    assign out_valid        = out_vld_reg;
    assign request_reenable = res_reg.request_reenable;
    assign reset_line_low   = res_reg.reset_line_low;
    assign recovery_state   = res_reg.recovery_state;
    assign attempts_used    = res_reg.attempts_used;
    assign data_fresh       = res_reg.data_fresh;
    assign attitude_invalid = res_reg.attitude_invalid;

    // A sensor reset always leaves the block requesting in soft re-enable.
    a_invalid_soft: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && attitude_invalid |->
            request_reenable && (recovery_state == STATE_SOFT))
        else $error("sensor reset result not in soft re-enable");

    // The healthy mode never carries a count of attempts.
    a_healthy_no_attempts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (recovery_state == STATE_HEALTHY) |-> (attempts_used == '0))
        else $error("healthy result with attempts pending");

    // A processed item always lands in the output register.
    a_move_lands: assert property (@(posedge clk) disable iff (!rst_n)
        move |=> out_vld_reg)
        else $error("processed item lost before the output register");

    // An item held by a stall stays in the input register.
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !out_free |=> in_vld_reg)
        else $error("stalled input item dropped");

endmodule

FILE: tb/sensor_recovery_supervisor_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sensor recovery supervisor checker
// Watches the configuration port and both item channels of the supervisor.
// Keeps its own copy of the timeouts and of the recovery state, works out the
// outcome of every accepted event and compares each result item against the
// oldest outcome still due. Failures and outstanding outcomes are reported
// to the testbench top.
// ----------------------------------------------------------------------------
module sensor_recovery_supervisor_checker
    import srs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [FUNC_W-1:0]   func,
    input  logic [TIME_W-1:0]   now_ms,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic                request_reenable,
    input  logic                reset_line_low,
    input  logic [STATE_W-1:0]  recovery_state,
    input  logic [ATT_W-1:0]    attempts_used,
    input  logic                data_fresh,
    input  logic                attitude_invalid,
    output int unsigned         failures,
    output int unsigned         pending,
    output int unsigned         results_checked,
    output int unsigned         hw_resets
);

    // Shadow of the timeouts and of the supervisor's recovery state.
    cfg_t               sup_cfg;
    logic [STATE_W-1:0] sup_mode;
    logic [TIME_W-1:0]  sup_since;
    logic [ATT_W-1:0]   sup_attempts;
    logic [TIME_W-1:0]  sup_last_good;
    logic               sup_seen;
    logic               sup_line_low;

    // Outcomes of accepted events whose result items have not come yet.
    res_t due_outcomes[$];

    // Apply one event to the shadow state and return the result it causes.
    function automatic res_t supervise_event(input logic [FUNC_W-1:0] code,
                                             input logic [TIME_W-1:0] t);
        res_t              r;
        logic [TIME_W-1:0] age;
        logic [TIME_W-1:0] held;
        logic              fresh;
        r = '0;
        if (code == FUNC_GOOD) begin
            sup_last_good = t;
            sup_seen      = 1'b1;
        end
        // A health check leaves the report time alone, so freshness before
        // and after the step is the same.
        age   = t - sup_last_good;
        held  = t - sup_since;
        fresh = sup_seen && (age < TIME_W'(sup_cfg.fresh_timeout_ms));
        case (code)
            FUNC_SENSOR_RESET: begin
                r.attitude_invalid = 1'b1;
                r.request_reenable = 1'b1;
                sup_mode           = STATE_SOFT;
                sup_since          = t;
                sup_attempts       = 4'd1;
            end
            FUNC_HEALTH: begin
                if (fresh) begin
                    // Back to healthy; a reset line held low stays low.
                    if (sup_mode != STATE_HEALTHY) begin
                        sup_mode     = STATE_HEALTHY;
                        sup_attempts = '0;
                    end
                end else begin
                    case (sup_mode)
                        STATE_HEALTHY: begin
                            if (sup_seen && age >= TIME_W'(sup_cfg.recovery_trigger_ms)) begin
                                r.request_reenable = 1'b1;
                                sup_mode           = STATE_SOFT;
                                sup_since          = t;
                                sup_attempts       = 4'd1;
                            end
                        end
                        STATE_SOFT: begin
                            if (held >= TIME_W'(sup_cfg.reenable_wait_ms)) begin
                                if (sup_attempts < sup_cfg.soft_attempts_max) begin
                                    r.request_reenable = 1'b1;
                                    sup_attempts       = sup_attempts + 4'd1;
                                end else begin
                                    sup_line_low = 1'b1;
                                    sup_mode     = STATE_PULSE;
                                    hw_resets++;
                                end
                                sup_since = t;
                            end
                        end
                        STATE_PULSE: begin
                            if (held >= TIME_W'(sup_cfg.reset_pulse_ms)) begin
                                sup_line_low = 1'b0;
                                sup_mode     = STATE_BOOT;
                                sup_since    = t;
                            end
                        end
                        default: begin
                            if (held >= TIME_W'(sup_cfg.boot_wait_ms)) begin
                                r.request_reenable = 1'b1;
                                sup_attempts       = '0;
                                sup_mode           = STATE_SOFT;
                                sup_since          = t;
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase
        r.reset_line_low = sup_line_low;
        r.recovery_state = sup_mode;
        r.attempts_used  = sup_attempts;
        r.data_fresh     = fresh;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // Register writes, event prediction and result comparison.
    always @(posedge clk or negedge rst_n) begin : monitor
        res_t want;
        if (!rst_n) begin
            sup_cfg         = CFG_RESET;
            sup_mode        = STATE_HEALTHY;
            sup_since       = '0;
            sup_attempts    = '0;
            sup_last_good   = '0;
            sup_seen        = 1'b0;
            sup_line_low    = 1'b0;
            failures        = 0;
            results_checked = 0;
            hw_resets       = 0;
            due_outcomes.delete();
            pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_FRESH_TIMEOUT: sup_cfg.fresh_timeout_ms    = pwdata[MS_W-1:0];
                    REG_RECOVERY_TRIG: sup_cfg.recovery_trigger_ms = pwdata[MS_W-1:0];
                    REG_REENABLE_WAIT: sup_cfg.reenable_wait_ms    = pwdata[MS_W-1:0];
                    REG_SOFT_ATT_MAX:  sup_cfg.soft_attempts_max   = pwdata[ATT_W-1:0];
                    REG_RESET_PULSE:   sup_cfg.reset_pulse_ms      = pwdata[MS_W-1:0];
                    REG_BOOT_WAIT:     sup_cfg.boot_wait_ms        = pwdata[MS_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall) begin
                if (due_outcomes.size() == 0) begin
                    $error("result item arrived with no event outstanding");
                    failures++;
                end else begin
                    want = due_outcomes.pop_front();
                    check_field("request_reenable", 32'(want.request_reenable),
                                32'(request_reenable));
                    check_field("reset_line_low", 32'(want.reset_line_low),
                                32'(reset_line_low));
                    check_field("recovery_state", 32'(want.recovery_state),
                                32'(recovery_state));
                    check_field("attempts_used", 32'(want.attempts_used),
                                32'(attempts_used));
                    check_field("data_fresh", 32'(want.data_fresh), 32'(data_fresh));
                    check_field("attitude_invalid", 32'(want.attitude_invalid),
                                32'(attitude_invalid));
                    results_checked++;
                end
            end
            if (in_valid && !in_stall)
                due_outcomes.push_back(supervise_event(func, now_ms));
            pending <= due_outcomes.size();
        end
    end

endmodule

FILE: tb/sensor_recovery_supervisor_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sensor recovery supervisor testbench
// Drives timestamped sensor events into the supervisor: a directed walk
// through the whole recovery cycle, then random event streams under several
// timeout settings, with bursty input, random output stalls and one long
// receiver hold-off. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module sensor_recovery_supervisor_top_test;
    import srs_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int unsigned NUM_SETTINGS    = 7;
    localparam int unsigned EVENTS_PER_SET  = 190;
    localparam int unsigned HOLD_OFF_CYCLES = 60;
    localparam int unsigned STALL_LIMIT     = 1000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [FUNC_W-1:0]  func = '0;
    logic [TIME_W-1:0]  now_ms = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               request_reenable;
    logic               reset_line_low;
    logic [STATE_W-1:0] recovery_state;
    logic [ATT_W-1:0]   attempts_used;
    logic               data_fresh;
    logic               attitude_invalid;

    int unsigned failures;
    int unsigned pending;
    int unsigned results_checked;
    int unsigned hw_resets;

    cfg_t              active_cfg = CFG_RESET;
    logic [TIME_W-1:0] clock_ms = '0;
    bit                hold_off_req = 1'b0;
    int unsigned       holds_done = 0;
    int unsigned       events_sent = 0;
    int unsigned       idle_cycles = 0;

    sensor_recovery_supervisor_top dut (.*);

    sensor_recovery_supervisor_checker checker_inst (.*);

    // 10 ns clock.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("sensor_recovery_supervisor_top test failed");
                $finish;
            end
        end
    end

    // Receiver: stretches of free flow, light, heavy and even stalling, plus
    // one long hold-off on request.
    initial begin : receiver
        int unsigned run;
        int unsigned kind;
        int unsigned i;
        forever begin
            if (hold_off_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
                holds_done++;
            end
            kind = $urandom_range(0, 3);
            run  = $urandom_range(1, 30);
            for (i = 0; i < run && !hold_off_req; i++) begin
                case (kind)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= $urandom_range(0, 1);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Offer one event item and wait until it is taken.
    task automatic send_event(input logic [FUNC_W-1:0] code, input logic [TIME_W-1:0] t);
        in_valid <= 1'b1;
        func     <= code;
        now_ms   <= t;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        events_sent++;
    endtask

    // Wait until every result due has come back.
    task automatic drain_results();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Setup and access cycles of one register write; psel stays high
    // between writes of the same group.
    task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
    endtask

    task automatic apply_setting(input cfg_t c);
        apb_write(REG_FRESH_TIMEOUT, DATA_W'(c.fresh_timeout_ms));
        apb_write(REG_RECOVERY_TRIG, DATA_W'(c.recovery_trigger_ms));
        apb_write(REG_REENABLE_WAIT, DATA_W'(c.reenable_wait_ms));
        apb_write(REG_SOFT_ATT_MAX, DATA_W'(c.soft_attempts_max));
        apb_write(REG_RESET_PULSE, DATA_W'(c.reset_pulse_ms));
        apb_write(REG_BOOT_WAIT, DATA_W'(c.boot_wait_ms));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        active_cfg = c;
    endtask

    // Timeout settings: defaults, all one, all maximum, all zero,
    // random short, random full range, then defaults written back.
    function automatic cfg_t setting_for(input int unsigned idx);
        cfg_t c;
        c = CFG_RESET;
        case (idx)
            1: c = '{default: 1};
            2: c = '{default: '1};
            3: c = '{default: '0};
            4: begin
                c.fresh_timeout_ms    = MS_W'($urandom_range(1, 1500));
                c.recovery_trigger_ms = MS_W'($urandom_range(1, 1500));
                c.reenable_wait_ms    = MS_W'($urandom_range(1, 1500));
                c.soft_attempts_max   = ATT_W'($urandom_range(1, 6));
                c.reset_pulse_ms      = MS_W'($urandom_range(1, 1500));
                c.boot_wait_ms        = MS_W'($urandom_range(1, 1500));
            end
            5: begin
                c.fresh_timeout_ms    = MS_W'($urandom_range(1, 65535));
                c.recovery_trigger_ms = MS_W'($urandom_range(1, 65535));
                c.reenable_wait_ms    = MS_W'($urandom_range(1, 65535));
                c.soft_attempts_max   = ATT_W'($urandom_range(1, 15));
                c.reset_pulse_ms      = MS_W'($urandom_range(1, 65535));
                c.boot_wait_ms        = MS_W'($urandom_range(1, 65535));
            end
            default: ;
        endcase
        return c;
    endfunction

    // Time advance between events, mostly landing on or beside a timeout
    // so that every recovery transition is reached, now and then a jump.
    function automatic logic [TIME_W-1:0] pick_step();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return $urandom_range(1, 3);
            2, 3:    return $urandom_range(0, active_cfg.fresh_timeout_ms);
            4:       return TIME_W'(active_cfg.fresh_timeout_ms);
            5:       return TIME_W'(active_cfg.recovery_trigger_ms);
            6:       return TIME_W'(active_cfg.reenable_wait_ms);
            7:       return TIME_W'(active_cfg.reset_pulse_ms);
            8:       return TIME_W'(active_cfg.boot_wait_ms);
            9:       return $urandom_range(0, 70000);
            10:      return TIME_W'(active_cfg.reenable_wait_ms) - 32'd1;
            11:      return $urandom;
            12:      return TIME_W'(active_cfg.boot_wait_ms) - 32'd1;
            default: return $urandom_range(0, 2 * active_cfg.reenable_wait_ms + 1);
        endcase
    endfunction

    // Directed walk: nothing seen, wrap of the clock, freshness edge,
    // recovery start, retries, reset pulse, boot wait, return to healthy
    // with the line still low, sensor reset and the unused event code.
    task automatic run_directed();
        logic [TIME_W-1:0] base;
        logic [TIME_W-1:0] rec;
        base = 32'hFFFF_FF00;
        rec  = base + 32'd1000;
        send_event(FUNC_HEALTH, 32'd5000);
        send_event(FUNC_UNUSED, 32'hFFFF_FFFF);
        send_event(FUNC_GOOD, base);
        send_event(FUNC_HEALTH, base + 32'd99);
        send_event(FUNC_HEALTH, base + 32'd100);
        send_event(FUNC_HEALTH, base + 32'd999);
        send_event(FUNC_HEALTH, rec);
        send_event(FUNC_HEALTH, rec + 32'd599);
        send_event(FUNC_HEALTH, rec + 32'd600);
        send_event(FUNC_HEALTH, rec + 32'd1200);
        send_event(FUNC_HEALTH, rec + 32'd1800);
        send_event(FUNC_HEALTH, rec + 32'd1809);
        send_event(FUNC_HEALTH, rec + 32'd1810);
        send_event(FUNC_HEALTH, rec + 32'd2110);
        send_event(FUNC_HEALTH, rec + 32'd2710);
        send_event(FUNC_HEALTH, rec + 32'd3310);
        send_event(FUNC_HEALTH, rec + 32'd3910);
        send_event(FUNC_HEALTH, rec + 32'd4510);
        send_event(FUNC_GOOD, rec + 32'd4515);
        send_event(FUNC_HEALTH, rec + 32'd4520);
        send_event(FUNC_SENSOR_RESET, rec + 32'd4600);
        send_event(FUNC_UNUSED, 32'd0);
        send_event(FUNC_GOOD, 32'd0);
        send_event(FUNC_HEALTH, 32'hFFFF_FFFF);
        in_valid <= 1'b0;
    endtask

    // Random event stream in bursts. Reports come and go in long spells so
    // that silences drive the recovery machine deep into its cycle.
    task automatic run_events(input int unsigned count, input bit hold);
        int unsigned       counted;
        int unsigned       burst;
        int unsigned       gap;
        int unsigned       roll;
        bit                reports_on;
        logic [FUNC_W-1:0] code;
        counted    = 0;
        reports_on = 1'b1;
        burst      = hold ? 16 : $urandom_range(1, 24);
        if (hold)
            hold_off_req = 1'b1;
        clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200000);
        while (counted < count) begin
            if ($urandom_range(0, 19) == 0)
                reports_on = !reports_on;
            roll = $urandom_range(0, 99);
            if (roll < 4)
                code = FUNC_UNUSED;
            else if (roll < 10)
                code = FUNC_SENSOR_RESET;
            else if (roll < (reports_on ? 45 : 12))
                code = FUNC_GOOD;
            else
                code = FUNC_HEALTH;
            clock_ms = clock_ms + pick_step();
            send_event(code, clock_ms);
            if (code != FUNC_UNUSED)
                counted++;
            burst--;
            if (burst == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                if (gap != 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                    : $urandom_range(1, 24);
            end
        end
        in_valid <= 1'b0;
    endtask

    // Stimulus and verdict.
    initial begin : stimulus
        int unsigned idx;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (idx = 0; idx < NUM_SETTINGS; idx++) begin
            if (idx != 0) begin
                drain_results();
                apply_setting(setting_for(idx));
            end
            run_events(EVENTS_PER_SET, idx == 2);
        end
        drain_results();
        repeat (4) @(posedge clk);
        $display("Run covered %0d events under %0d timeout settings; %0d results checked.",
                 events_sent, NUM_SETTINGS, results_checked);
        $display("Hardware reset pulses predicted: %0d; long receiver hold-offs: %0d.",
                 hw_resets, holds_done);
        if (failures == 0)
            $display("sensor_recovery_supervisor_top test passed");
        else
            $display("sensor_recovery_supervisor_top test failed");
        $finish;
    end

endmodule

FILE: files.f
hdl/srs_pkg.sv
hdl/srs_regs.sv
hdl/srs_core.sv
hdl/sensor_recovery_supervisor_top.sv
tb/sensor_recovery_supervisor_checker.sv
tb/sensor_recovery_supervisor_top_test.sv
